### rtl/core/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Shared codes and types of the positional list core and its cells.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int VALUE_W = 32;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // cell operations
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    // command broadcast to every cell
    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;   // insert value, or head value on rotate
    } plid_cell_cmd_t;

    // per-cell position flags
    typedef struct packed {
        logic at_pos;     // cell index equals request position
        logic past_pos;   // cell index above request position
        logic tail;       // cell holds the last valid entry
    } plid_cell_sel_t;

endpackage

### rtl/core/positional_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core
// Ordered list of up to DEPTH signed 32-bit entries with insert, delete, dump.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transaction:
//   req_type, position, item_value. Output channel (out_valid/out_ready)
//   carries result transactions: out_value, status, last.
//   For insert and delete the whole row of cells shifts at once, and the
//   single result sits in the output register the cycle after the request
//   is accepted. A dump of N entries gives N results, one per cycle while
//   the receiver takes them, by rotating the row toward cell 0 and reading
//   cell 0; after N steps the row is back in order.
//   Request code 3 is accepted and dropped without a result.
//   Reset empties the list at once (count cleared); no clearing pass.
//   A stalled receiver holds the output register; in_ready drops until the
//   pending result is taken, and a dump pauses in place.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core
    import plid_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                req_type,
    input  logic [4:0]                position,
    input  logic signed [VALUE_W-1:0] item_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [1:0]                status,
    output logic                      last
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                      state_reg,  state_next;
    logic [CW-1:0]             count_reg,  count_next;
    logic [CW-1:0]             remain_reg, remain_next;   // dump entries still to send
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [1:0]                status_reg,    status_next;
    logic                      last_reg,      last_next;

    plid_cell_cmd_t            cmd;
    plid_cell_sel_t            sel   [DEPTH];
    logic signed [VALUE_W-1:0] cell_q[DEPTH];
    logic signed [VALUE_W-1:0] picked;     // entry at the request position

    logic out_free;
    logic in_fire;
    logic pos_gt_count;
    logic pos_ge_count;
    logic full;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;

    assign pos_gt_count = 32'(position) >  32'(count_reg);
    assign pos_ge_count = 32'(position) >= 32'(count_reg);
    assign full         = 32'(count_reg) >= DEPTH;

    // position flags, one set per cell
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            sel[i].at_pos   = 32'(position) == i;
            sel[i].past_pos = 32'(position) <  i;
            sel[i].tail     = (32'(count_reg) - 32'd1) == i;
        end
    end

    // AND-OR pick of the entry being deleted
    always_comb
    begin
        picked = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel[i].at_pos)
                picked = picked | cell_q[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        cmd.op         = CELL_HOLD;
        cmd.value      = item_value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (req_type)
                        REQ_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            out_value_next = '0;
                            if (pos_gt_count)
                                status_next = ST_RANGE;
                            else if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                status_next    = ST_OK;
                                out_value_next = item_value;
                                cmd.op         = CELL_INSERT;
                                count_next     = count_reg + 1'b1;
                            end
                        end
                        REQ_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            out_value_next = '0;
                            if (pos_ge_count)
                                status_next = ST_RANGE;
                            else
                            begin
                                status_next    = ST_OK;
                                out_value_next = picked;
                                cmd.op         = CELL_DELETE;
                                count_next     = count_reg - 1'b1;
                            end
                        end
                        REQ_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                last_next      = 1'b1;
                                out_value_next = '0;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                state_next  = S_DUMP;
                                remain_next = count_reg;
                            end
                        end
                        default:
                        begin
                            // unused code: dropped
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    // send head, rotate the valid part of the row by one
                    out_valid_next = 1'b1;
                    out_value_next = cell_q[0];
                    status_next    = ST_OK;
                    last_next      = remain_reg == CW'(1);
                    cmd.op         = CELL_ROTATE;
                    cmd.value      = cell_q[0];
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == CW'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the row of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_v;
        logic signed [VALUE_W-1:0] right_v;
        if (g == 0)
        begin : g_first
            assign left_v = item_value;
        end
        else
        begin : g_left
            assign left_v = cell_q[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_endrow
            assign right_v = cell_q[g];
        end
        else
        begin : g_right
            assign right_v = cell_q[g+1];
        end
        plid_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .sel         (sel[g]),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("entry count above DEPTH");

    a_dump_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req_type == REQ_DUMP && count_reg != '0) |=> (state_reg == S_DUMP))
        else $error("nonempty dump did not start streaming");

    a_dump_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> $stable(count_reg))
        else $error("entry count changed during dump");

    a_dump_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (remain_reg != '0 && remain_reg <= count_reg))
        else $error("dump remaining count out of range");

endmodule

### rtl/core/plid_cell.sv
// ----------------------------------------------------------------------------
// plid_cell
// One list slot: holds an entry, shifts from its neighbors on insert, delete and rotate.
// ----------------------------------------------------------------------------
module plid_cell
    import plid_pkg::*;
(
    input  logic                      clk,
    input  plid_cell_cmd_t            cmd,
    input  plid_cell_sel_t            sel,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic signed [VALUE_W-1:0] right_value,
    output logic signed [VALUE_W-1:0] value
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
            CELL_INSERT:
            begin
                if (sel.at_pos)
                    value_next = cmd.value;
                else if (sel.past_pos)
                    value_next = left_value;
            end
            CELL_DELETE:
            begin
                if (sel.at_pos || sel.past_pos)
                    value_next = right_value;
            end
            CELL_ROTATE:
            begin
                value_next = sel.tail ? cmd.value : right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_list_insert_delete_core. A directed
// table covers the edge cases: empty, full, out-of-range positions, head,
// middle and tail edits, and the dropped request code. A long random run
// follows that sweeps the list between empty and full. Every result
// transaction is checked against a local model of the list.
// ----------------------------------------------------------------------------
module testbench;
    import plid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = 16;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 290;
    localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;    // longer than a full dump
    localparam int CYCLE_LIMIT  = 200000;

    // request code that the core drops without a result
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // one result transaction
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
        logic                      last;
    } list_result_t;

    // one row of the directed table; exp_* used only when typed is set
    typedef struct packed {
        logic [1:0]                req;
        logic [4:0]                pos;
        logic signed [VALUE_W-1:0] value;
        int                        reps;    // repeated with value + k
        logic                      typed;
        logic signed [VALUE_W-1:0] exp_value;
        logic [1:0]                exp_status;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------------
    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic [1:0]                req_type   = REQ_INSERT;
    logic [4:0]                position   = 5'd0;
    logic signed [VALUE_W-1:0] item_value = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic signed [VALUE_W-1:0] out_value;
    logic [1:0]                status;
    logic                      last;

    positional_list_insert_delete_core #(
        .DEPTH (LIST_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .position   (position),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_value  (out_value),
        .status     (status),
        .last       (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // List model: own copy of the entries and the count. Results of each
    // accepted request are queued in due_results, oldest first.
    // ------------------------------------------------------------------------
    logic signed [VALUE_W-1:0] list_entries [LIST_DEPTH];
    int                        list_count = 0;
    list_result_t              due_results [$];

    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;    // chance per cycle that the sender idles
    int   recv_stall_pct = 0;    // chance per cycle that the receiver stalls
    logic hold_active    = 1'b0;
    event hold_off_ev;

    function automatic void queue_result(logic signed [VALUE_W-1:0] v,
                                         logic [1:0] st, logic lst);
        list_result_t r;
        r.value  = v;
        r.status = st;
        r.last   = lst;
        due_results.push_back(r);
    endfunction

    // Apply one accepted request to the model list and queue its results.
    function automatic void list_step(logic [1:0] req, logic [4:0] pos,
                                      logic signed [VALUE_W-1:0] v);
        int p;
        logic signed [VALUE_W-1:0] removed;
        p = int'(pos);
        case (req)
            REQ_INSERT:
            begin
                if (p > list_count)
                    queue_result('0, ST_RANGE, 1'b1);
                else if (list_count >= LIST_DEPTH)
                    queue_result('0, ST_FULL, 1'b1);
                else
                begin
                    for (int i = list_count; i > p; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[p] = v;
                    list_count++;
                    queue_result(v, ST_OK, 1'b1);
                end
            end
            REQ_DELETE:
            begin
                if (p >= list_count)
                    queue_result('0, ST_RANGE, 1'b1);
                else
                begin
                    removed = list_entries[p];
                    for (int i = p; i + 1 < list_count; i++)
                        list_entries[i] = list_entries[i+1];
                    list_count--;
                    queue_result(removed, ST_OK, 1'b1);
                end
            end
            REQ_DUMP:
            begin
                if (list_count == 0)
                    queue_result('0, ST_EMPTY, 1'b1);
                else
                    for (int i = 0; i < list_count; i++)
                        queue_result(list_entries[i], ST_OK, i + 1 == list_count);
            end
            default: ;  // dropped code: no result, no change
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Mostly random values, with the extremes now and then.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Called in the time step of a rising edge; returns in
    // the step of the accepting edge, after the model has been updated.
    // ------------------------------------------------------------------------
    task automatic send_req(logic [1:0] req, logic [4:0] pos,
                            logic signed [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        position   <= pos;
        item_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        list_step(req, pos, v);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_active)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // hold-off counted here so the sender keeps offering meanwhile
    initial
    begin
        @(hold_off_ev);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result checker: each transaction against the oldest due result
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
                flag_mismatch($sformatf("unexpected result value %0d status %0d last %0b",
                                        out_value, status, last));
            else
            begin
                want = due_results.pop_front();
                if (out_value !== want.value)
                    flag_mismatch($sformatf("out_value %0d, want %0d", out_value, want.value));
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, due_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    dir_row_t directed_rows [16];

    initial
    begin
        int               done_items;
        int               pick;
        bit               growing;
        bit               hold_fired;
        logic [1:0]       req;
        logic [4:0]       pos;
        logic signed [VALUE_W-1:0] v;

        // Directed table. Typed rows carry their single result; the rest
        // are checked through the model.
        directed_rows = '{
            // dump of an empty list
            '{REQ_DUMP,   5'd0,  32'sd0,          1,  1'b1, 32'sd0,          ST_EMPTY},
            // delete on an empty list
            '{REQ_DELETE, 5'd0,  32'sd0,          1,  1'b1, 32'sd0,          ST_RANGE},
            // first entry, then append, middle and head inserts
            '{REQ_INSERT, 5'd0,  32'sh8000_0000,  1,  1'b1, 32'sh8000_0000,  ST_OK},
            '{REQ_INSERT, 5'd1,  32'sh7FFF_FFFF,  1,  1'b1, 32'sh7FFF_FFFF,  ST_OK},
            '{REQ_INSERT, 5'd1,  -32'sd1,         1,  1'b1, -32'sd1,         ST_OK},
            '{REQ_INSERT, 5'd0,  32'sd0,          1,  1'b1, 32'sd0,          ST_OK},
            // dropped request code: nothing comes back
            '{REQ_UNUSED, 5'd31, 32'sh1234_5678,  1,  1'b0, 32'sd0,          ST_OK},
            '{REQ_DUMP,   5'd31, 32'sd0,          1,  1'b0, 32'sd0,          ST_OK},
            // positions far past the end
            '{REQ_DELETE, 5'd31, 32'sd0,          1,  1'b1, 32'sd0,          ST_RANGE},
            '{REQ_INSERT, 5'd31, -32'sd1,         1,  1'b1, 32'sd0,          ST_RANGE},
            // head delete, then fill up to DEPTH
            '{REQ_DELETE, 5'd0,  32'sd0,          1,  1'b0, 32'sd0,          ST_OK},
            '{REQ_INSERT, 5'd1,  32'sh5A5A_0000,  13, 1'b0, 32'sd0,          ST_OK},
            // insert at the count into a full list
            '{REQ_INSERT, 5'd16, 32'sh0BAD_CAFE,  1,  1'b1, 32'sd0,          ST_FULL},
            '{REQ_DUMP,   5'd0,  32'sd0,          1,  1'b0, 32'sd0,          ST_OK},
            // delete at the count, then the tail
            '{REQ_DELETE, 5'd16, 32'sd0,          1,  1'b1, 32'sd0,          ST_RANGE},
            '{REQ_DELETE, 5'd15, 32'sd0,          1,  1'b0, 32'sd0,          ST_OK}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
        begin
            for (int k = 0; k < directed_rows[n].reps; k++)
            begin
                send_req(directed_rows[n].req, directed_rows[n].pos,
                         directed_rows[n].value + k);
                if (directed_rows[n].typed)
                    due_results[due_results.size()-1] =
                        '{directed_rows[n].exp_value, directed_rows[n].exp_status, 1'b1};
            end
        end

        // Random part: mostly well-formed edits around the current count,
        // with a trend that sweeps the list between empty and full; the
        // rest is noise positions and the dropped code.
        done_items = 0;
        growing    = 1'b0;
        hold_fired = 1'b0;
        while (done_items < RANDOM_ITEMS)
        begin
            // idling phases: none, sender, receiver, both light
            case (done_items * 4 / RANDOM_ITEMS)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase

            // long receiver hold-off while the sender keeps going
            if (!hold_fired && done_items == 40)
            begin
                -> hold_off_ev;
                hold_fired = 1'b1;
            end

            pick = $urandom_range(0, 99);
            v    = pick_value();
            if (pick < 5)
            begin
                req = REQ_UNUSED;
                pos = 5'($urandom);
            end
            else if (pick < 15)
            begin
                req = 2'($urandom_range(0, 2));
                pos = 5'($urandom_range(0, 31));
            end
            else if (pick < 25)
            begin
                req = REQ_DUMP;
                pos = 5'($urandom);
            end
            else if (pick < (growing ? 78 : 42))
            begin
                req = REQ_INSERT;
                pos = 5'($urandom_range(0, list_count));
            end
            else
            begin
                req = REQ_DELETE;
                pos = (list_count == 0) ? 5'($urandom_range(0, 31))
                                        : 5'($urandom_range(0, list_count - 1));
            end

            send_req(req, pos, v);
            if (req != REQ_UNUSED)
                done_items++;

            // turn around now and then once a bound is reached
            if (list_count == LIST_DEPTH && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (list_count == 0 && $urandom_range(0, 3) == 0)
                growing = 1'b1;
        end

        in_valid       <= 1'b0;
        recv_stall_pct  = 0;

        while (due_results.size() != 0)
            @(posedge clk);
        // any stray result after the last due one shows up here
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
